// ===== rtl/zstd_frame_header_parser_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Zstandard frame header parser
// Shared helpers for the concurrent checks on the top-level ports.
// ---------------------------------------------------------------------------
`ifndef ZSTD_FRAME_HEADER_PARSER_TOP_MACROS_SVH
`define ZSTD_FRAME_HEADER_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ZFHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zfhp check failed");

// next-cycle implication, disabled during reset
`define ZFHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zfhp check failed");

`endif

// ===== rtl/zfhp_pkg.sv =====
// ---------------------------------------------------------------------------
// Zstandard frame header parser package
// Status codes, result record and descriptor decode helpers.
// ---------------------------------------------------------------------------
package zfhp_pkg;

  localparam logic [31:0] FRAME_MAGIC = 32'hFD2FB528;
  localparam logic [4:0]  MIN_HEADER  = 5'd5;
  localparam logic [4:0]  POS_MAX     = 5'd31;
  localparam logic [5:0]  WLOG_BASE   = 6'd10;
  localparam logic [63:0] FCS2_OFFSET = 64'd256;
  localparam logic [3:0]  FCS_LEN_TAB [4] = '{4'd0, 4'd2, 4'd4, 4'd8};

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CORRUPT = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  hdr_bytes;
    logic [7:0]  descriptor;
    logic        has_checksum;
    logic        single_seg;
    logic [5:0]  win_log;
    logic [63:0] win_bytes;
    logic [31:0] win_bytes_sat;
    logic [31:0] dict_id;
    logic [63:0] frame_bytes;
    logic        has_frame_bytes;
  } result_t;

  function automatic logic [4:0] dict_start(input logic [7:0] d);
    return d[5] ? 5'd5 : 5'd6;
  endfunction

  function automatic logic [2:0] dict_len(input logic [7:0] d);
    logic [2:0] len;
    case (d[1:0])
      2'd0:    len = 3'd0;
      2'd1:    len = 3'd1;
      2'd2:    len = 3'd2;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] fcs_len(input logic [7:0] d);
    return (d[5] && d[7:6] == 2'd0) ? 4'd1 : FCS_LEN_TAB[d[7:6]];
  endfunction

  function automatic logic [4:0] hdr_total(input logic [7:0] d);
    return dict_start(d) + {2'd0, dict_len(d)} + {1'b0, fcs_len(d)};
  endfunction

  // (8 + mantissa) << (exponent + 7) equals 2^wlog + (2^wlog / 8) * mantissa
  function automatic logic [63:0] window_from_byte(input logic [7:0] w);
    logic [63:0] m;
    logic [5:0]  sh;
    m  = {60'd0, 1'b1, w[2:0]};
    sh = {1'b0, w[7:3]} + 6'd7;
    return m << sh;
  endfunction

endpackage

// ===== rtl/zstd_frame_header_parser_top.sv =====
// ---------------------------------------------------------------------------
// Zstandard frame header parser
// Byte-wide frame header decode with one result beat per buffer.
// ---------------------------------------------------------------------------
// Input channel: one byte per beat (data_byte), last_byte marks the final
// byte of a buffer. The buffer must start at the first byte of a frame.
// Output channel: one result beat per buffer with status, header length and
// the decoded descriptor, window, dictionary ID and content size fields.
// Throughput: one input beat per cycle while no result beat is held by
// out_stall, set by the single decode stage between the input register and
// the result register. The byte that decides the result passes the input
// register, then the result register, where out_valid rises with the beat.
// Bytes after the decision are dropped without a result until the final byte,
// which restarts the parser.
// Reset clears the parser state and both valid flags; nothing is pending.
// When the receiver stalls, the result register holds, the input register
// fills and in_stall rises; no beat is lost.
// ---------------------------------------------------------------------------
module zstd_frame_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  hdr_bytes,
  output logic [7:0]  descriptor,
  output logic        has_checksum,
  output logic        single_seg,
  output logic [5:0]  win_log,
  output logic [63:0] win_bytes,
  output logic [31:0] win_bytes_sat,
  output logic [31:0] dict_id,
  output logic [63:0] frame_bytes,
  output logic        has_frame_bytes
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        advance;
  logic        take;

  logic [4:0]  pos, pos_next, pos_inc;
  logic [31:0] magic, magic_next;
  logic [7:0]  desc, desc_next;
  logic [4:0]  target, target_next;
  logic [7:0]  window_byte, window_next;
  logic [31:0] dict_acc, dict_next;
  logic [63:0] size_acc, size_next;
  logic        given, given_next;

  logic        corrupt, ok, short_buf, fire;
  logic [4:0]  ds, fs, dict_off, size_off;
  logic [63:0] csize, wsize;

  zfhp_pkg::result_t rslt, rslt_next;

  assign advance  = !out_valid || !out_stall;
  assign take     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_comb begin
    pos_inc     = (pos == zfhp_pkg::POS_MAX) ? pos : pos + 5'd1;
    pos_next    = pos;
    magic_next  = magic;
    desc_next   = desc;
    target_next = target;
    window_next = window_byte;
    dict_next   = dict_acc;
    size_next   = size_acc;
    given_next  = given;
    corrupt     = 1'b0;
    ok          = 1'b0;
    short_buf   = 1'b0;
    ds          = zfhp_pkg::dict_start(desc);
    fs          = ds + {2'd0, zfhp_pkg::dict_len(desc)};
    dict_off    = pos - ds;
    size_off    = pos - fs;
    if (!given) begin
      if (pos < 5'd4) begin
        magic_next = {s1_byte, magic[31:8]};
      end else if (pos == 5'd4) begin
        desc_next = s1_byte;
        if (magic != zfhp_pkg::FRAME_MAGIC || s1_byte[3]) begin
          corrupt = 1'b1;
        end else begin
          target_next = zfhp_pkg::hdr_total(s1_byte);
        end
      end else if (!desc[5] && pos == 5'd5) begin
        window_next = s1_byte;
      end else if (pos < fs) begin
        for (int i = 0; i < 4; i++) begin
          if (dict_off[1:0] == 2'(i)) begin
            dict_next[i*8 +: 8] = dict_acc[i*8 +: 8] | s1_byte;
          end
        end
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (size_off[2:0] == 3'(i)) begin
            size_next[i*8 +: 8] = size_acc[i*8 +: 8] | s1_byte;
          end
        end
      end
      if (!corrupt) begin
        pos_next  = pos_inc;
        ok        = (pos_inc >= zfhp_pkg::MIN_HEADER) && (pos_inc == target_next);
        short_buf = !ok && s1_last;
      end
      given_next = corrupt || ok || short_buf;
    end
  end

  assign fire = corrupt || ok || short_buf;

  always_comb begin
    csize = size_next;
    if (zfhp_pkg::fcs_len(desc_next) == 4'd2) begin
      csize = size_next + zfhp_pkg::FCS2_OFFSET;
    end
    wsize = desc_next[5] ? csize : zfhp_pkg::window_from_byte(window_next);
    rslt_next = '0;
    if (ok) begin
      rslt_next.status          = zfhp_pkg::STATUS_OK;
      rslt_next.hdr_bytes       = target_next;
      rslt_next.descriptor      = desc_next;
      rslt_next.has_checksum    = desc_next[2];
      rslt_next.single_seg      = desc_next[5];
      rslt_next.win_log         = desc_next[5] ? 6'd0 :
                                  {1'b0, window_next[7:3]} + zfhp_pkg::WLOG_BASE;
      rslt_next.win_bytes       = wsize;
      rslt_next.win_bytes_sat   = (wsize[63:32] != 32'd0) ? 32'hFFFFFFFF : wsize[31:0];
      rslt_next.dict_id         = dict_next;
      rslt_next.frame_bytes     = csize;
      rslt_next.has_frame_bytes = zfhp_pkg::fcs_len(desc_next) != 4'd0;
    end else if (corrupt) begin
      rslt_next.status    = zfhp_pkg::STATUS_CORRUPT;
      rslt_next.hdr_bytes = zfhp_pkg::MIN_HEADER;
    end else begin
      rslt_next.status    = zfhp_pkg::STATUS_SHORT;
      rslt_next.hdr_bytes = (pos_inc < zfhp_pkg::MIN_HEADER) ?
                            zfhp_pkg::MIN_HEADER : target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 5'd0;
      magic       <= 32'd0;
      desc        <= 8'd0;
      target      <= zfhp_pkg::MIN_HEADER;
      window_byte <= 8'd0;
      dict_acc    <= 32'd0;
      size_acc    <= 64'd0;
      given       <= 1'b0;
    end else if (take) begin
      if (s1_last) begin
        pos         <= 5'd0;
        magic       <= 32'd0;
        desc        <= 8'd0;
        target      <= zfhp_pkg::MIN_HEADER;
        window_byte <= 8'd0;
        dict_acc    <= 32'd0;
        size_acc    <= 64'd0;
        given       <= 1'b0;
      end else begin
        pos         <= pos_next;
        magic       <= magic_next;
        desc        <= desc_next;
        target      <= target_next;
        window_byte <= window_next;
        dict_acc    <= dict_next;
        size_acc    <= size_next;
        given       <= given_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take && fire;
    end
    if (advance) begin
      rslt <= rslt_next;
    end
  end

  assign status          = rslt.status;
  assign hdr_bytes       = rslt.hdr_bytes;
  assign descriptor      = rslt.descriptor;
  assign has_checksum    = rslt.has_checksum;
  assign single_seg      = rslt.single_seg;
  assign win_log         = rslt.win_log;
  assign win_bytes       = rslt.win_bytes;
  assign win_bytes_sat   = rslt.win_bytes_sat;
  assign dict_id         = rslt.dict_id;
  assign frame_bytes     = rslt.frame_bytes;
  assign has_frame_bytes = rslt.has_frame_bytes;

endmodule

// ===== rtl/zfhp_checker.sv =====
// ---------------------------------------------------------------------------
// Zstandard frame header parser port checker
// Concurrent checks on both channels, bound to the top level.
// ---------------------------------------------------------------------------
`include "zstd_frame_header_parser_top_macros.svh"

module zfhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [4:0]  hdr_bytes,
  input logic [7:0]  descriptor,
  input logic        has_checksum,
  input logic        single_seg,
  input logic [5:0]  win_log,
  input logic [63:0] win_bytes,
  input logic [31:0] win_bytes_sat,
  input logic [31:0] dict_id,
  input logic [63:0] frame_bytes,
  input logic        has_frame_bytes
);

  logic ok_beat, fail_beat, fail_clear, ok_shape, clamp_good;

  assign ok_beat    = out_valid && status == zfhp_pkg::STATUS_OK;
  assign fail_beat  = out_valid && status != zfhp_pkg::STATUS_OK;
  assign fail_clear = descriptor == 8'd0 && win_bytes == 64'd0 && win_bytes_sat == 32'd0 &&
                      dict_id == 32'd0 && frame_bytes == 64'd0 && !has_frame_bytes &&
                      !has_checksum && !single_seg && win_log == 6'd0;
  assign ok_shape   = hdr_bytes >= 5'd6 && hdr_bytes <= 5'd18 &&
                      single_seg == descriptor[5] && !descriptor[3];
  assign clamp_good = (win_bytes[63:32] == 32'd0) ? (win_bytes_sat == win_bytes[31:0]) :
                      (win_bytes_sat == 32'hFFFFFFFF);

  // hold a stalled input beat
  `ZFHP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(data_byte) && $stable(last_byte))

  // hold a stalled result beat
  `ZFHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hdr_bytes))

  // clear every decoded field on a failed parse
  `ZFHP_ASSERT_NOW(a_fail_zero, fail_beat, fail_clear)

  // report a full header of six to eighteen bytes on success
  `ZFHP_ASSERT_NOW(a_ok_len, ok_beat, ok_shape)

  // saturate the clamped window to 32 bits
  `ZFHP_ASSERT_NOW(a_clamp, ok_beat, clamp_good)

endmodule

bind zstd_frame_header_parser_top zfhp_checker u_zfhp_checker (.*);

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// Zstandard frame header parser testbench
// Streams byte buffers (directed frames, then random well-formed, truncated,
// corrupt and noise buffers) through the parser. Predicts each header result
// beat and compares every field in arrival order. Idling changes between
// three phases, and a long output hold backs up the input side.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES   = 690;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [4:0]  hdr_bytes;
  logic [7:0]  descriptor;
  logic        has_checksum;
  logic        single_seg;
  logic [5:0]  win_log;
  logic [63:0] win_bytes;
  logic [31:0] win_bytes_sat;
  logic [31:0] dict_id;
  logic [63:0] frame_bytes;
  logic        has_frame_bytes;

  beat_t             byte_q[$];
  beat_t             next_beat;
  zfhp_pkg::result_t header_expect_q[$];
  zfhp_pkg::result_t got_header;
  logic [7:0]        frame_q[$];

  int send_idle_pct = 12;
  int recv_idle_pct = 78;
  int bytes_taken = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // parser state
  logic [4:0]  pos;
  logic [31:0] magic_sr;
  logic [7:0]  desc_q;
  logic [4:0]  hdr_need;
  logic [7:0]  win_q;
  logic [31:0] dict_acc;
  logic [63:0] size_acc;
  logic        done_q;

  zstd_frame_header_parser_top DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .hdr_bytes       (hdr_bytes),
    .descriptor      (descriptor),
    .has_checksum    (has_checksum),
    .single_seg      (single_seg),
    .win_log         (win_log),
    .win_bytes       (win_bytes),
    .win_bytes_sat   (win_bytes_sat),
    .dict_id         (dict_id),
    .frame_bytes     (frame_bytes),
    .has_frame_bytes (has_frame_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int dict_bytes(input logic [7:0] d);
    return (d[1:0] == 2'd3) ? 4 : int'(d[1:0]);
  endfunction

  function automatic int fcs_bytes(input logic [7:0] d);
    case (d[7:6])
      2'd0:    return d[5] ? 1 : 0;
      2'd1:    return 2;
      2'd2:    return 4;
      default: return 8;
    endcase
  endfunction

  task automatic parser_clear();
    pos = '0;
    magic_sr = '0;
    desc_q = '0;
    hdr_need = 5'd5;
    win_q = '0;
    dict_acc = '0;
    size_acc = '0;
    done_q = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    zfhp_pkg::result_t r;
    logic              hit;
    int                p;
    int                ds;
    int                fs;
    int                flen;
    int                wlog;
    logic [63:0]       csz;
    logic [63:0]       wsz;
    logic [63:0]       base;
    r = '0;
    hit = 1'b0;
    p = int'(pos);
    if (done_q) begin
      if (fin) parser_clear();
    end else begin
      if (p < 4) begin
        magic_sr = {b, magic_sr[31:8]};
      end else if (p == 4) begin
        desc_q = b;
        if (magic_sr != zfhp_pkg::FRAME_MAGIC || b[3]) begin
          r.status = zfhp_pkg::STATUS_CORRUPT;
          r.hdr_bytes = 5'd5;
          hit = 1'b1;
        end else begin
          hdr_need = 5'((b[5] ? 5 : 6) + dict_bytes(b) + fcs_bytes(b));
        end
      end else begin
        ds = desc_q[5] ? 5 : 6;
        fs = ds + dict_bytes(desc_q);
        if (!desc_q[5] && p == 5) win_q = b;
        else if (p < fs) dict_acc |= {24'd0, b} << (8 * ((p - ds) & 3));
        else size_acc |= {56'd0, b} << (8 * ((p - fs) & 7));
      end
      if (!hit) begin
        if (p < 31) p++;
        pos = 5'(p);
        if (p >= 5 && p == int'(hdr_need)) begin
          flen = fcs_bytes(desc_q);
          csz = size_acc;
          if (flen == 2) csz += 64'd256;
          if (desc_q[5]) begin
            wlog = 0;
            wsz = csz;
          end else begin
            wlog = int'(win_q[7:3]) + 10;
            base = 64'd1 << wlog;
            wsz = base + (base >> 3) * win_q[2:0];
          end
          r.status = zfhp_pkg::STATUS_OK;
          r.hdr_bytes = hdr_need;
          r.descriptor = desc_q;
          r.has_checksum = desc_q[2];
          r.single_seg = desc_q[5];
          r.win_log = 6'(wlog);
          r.win_bytes = wsz;
          r.win_bytes_sat = (wsz > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wsz[31:0];
          r.dict_id = dict_acc;
          r.frame_bytes = csz;
          r.has_frame_bytes = (flen != 0);
          hit = 1'b1;
        end else if (fin) begin
          r.status = zfhp_pkg::STATUS_SHORT;
          r.hdr_bytes = (p < 5) ? 5'd5 : hdr_need;
          hit = 1'b1;
        end
      end
      if (fin) parser_clear();
      else if (hit) done_q = 1'b1;
      if (hit) header_expect_q.push_back(r);
    end
  endtask

  task automatic build_frame(input logic [7:0] d, input int fill);
    int body;
    frame_q = {zfhp_pkg::FRAME_MAGIC[7:0], zfhp_pkg::FRAME_MAGIC[15:8],
               zfhp_pkg::FRAME_MAGIC[23:16], zfhp_pkg::FRAME_MAGIC[31:24], d};
    body = (d[5] ? 0 : 1) + dict_bytes(d) + fcs_bytes(d);
    repeat (body) frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic cut_frame(input int keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endtask

  task automatic add_trailing(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic send_frame();
    beat_t bt;
    foreach (frame_q[i]) begin
      bt.data = frame_q[i];
      bt.fin = (i == frame_q.size() - 1);
      byte_q.push_back(bt);
    end
  endtask

  task automatic add_random_buffer();
    logic [7:0] d;
    int         kind;
    int         idx;
    kind = $urandom_range(99);
    d = 8'($urandom);
    d[3] = 1'b0;
    build_frame(d, -1);
    if (kind < 8) begin
      idx = $urandom_range(3);
      frame_q[idx] = frame_q[idx] ^ (8'd1 << $urandom_range(7));
    end else if (kind < 14) begin
      frame_q[4][3] = 1'b1;
    end else if (kind < 28) begin
      cut_frame($urandom_range(frame_q.size() - 1, 1));
    end else if (kind < 34) begin
      frame_q.delete();
      repeat ($urandom_range(12, 1)) frame_q.push_back(8'($urandom));
    end
    if ((kind < 14 || kind >= 34) && $urandom_range(1) == 1)
      add_trailing($urandom_range(4, 1));
    send_frame();
  endtask

  task automatic add_random_bytes(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      add_random_buffer();
      sent += frame_q.size();
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || header_expect_q.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    frame_q = {zfhp_pkg::FRAME_MAGIC[7:0]};
    send_frame();
    build_frame(8'h00, 0);
    cut_frame(4);
    send_frame();
    build_frame(8'h00, 0);
    frame_q[3] = 8'h00;
    send_frame();
    build_frame(8'h08, 0);
    add_trailing(2);
    send_frame();
    build_frame(8'hC3, 0);
    cut_frame(5);
    send_frame();
    build_frame(8'hC3, -1);
    cut_frame(10);
    send_frame();
    build_frame(8'h00, 0);
    send_frame();
    build_frame(8'h00, 8'hFF);
    send_frame();
    build_frame(8'h20, 8'hFF);
    send_frame();
    build_frame(8'h60, 8'hFF);
    send_frame();
    build_frame(8'hA0, 8'hFF);
    send_frame();
    build_frame(8'hE0, 8'hFF);
    send_frame();
    build_frame(8'hC3, 8'hFF);
    add_trailing(3);
    send_frame();
    build_frame(8'h25, -1);
    send_frame();
    build_frame(8'h42, 8'h80);
    send_frame();
    build_frame(8'h83, -1);
    send_frame();
    build_frame(8'hF7, 8'hA5);
    send_frame();
    build_frame(8'h14, -1);
    send_frame();

    add_random_bytes(RANDOM_BYTES / 3);
    drain();
    send_idle_pct = 78;
    recv_idle_pct = 12;
    add_random_bytes(RANDOM_BYTES / 3);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_bytes(RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));
    drain();

    if (mismatches == 0 && header_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      data_byte <= '0;
      last_byte <= 1'b0;
      parser_clear();
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(data_byte, last_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = byte_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_beat.data;
          last_byte <= next_beat.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= 120) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (header_expect_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual status %0d length %0d",
                 $time, status, hdr_bytes);
        mismatches++;
      end else begin
        got_header = header_expect_q.pop_front();
        check_field("status", got_header.status, status);
        check_field("hdr_bytes", got_header.hdr_bytes, hdr_bytes);
        check_field("descriptor", got_header.descriptor, descriptor);
        check_field("has_checksum", got_header.has_checksum, has_checksum);
        check_field("single_seg", got_header.single_seg, single_seg);
        check_field("win_log", got_header.win_log, win_log);
        check_field("win_bytes", got_header.win_bytes, win_bytes);
        check_field("win_bytes_sat", got_header.win_bytes_sat, win_bytes_sat);
        check_field("dict_id", got_header.dict_id, dict_id);
        check_field("frame_bytes", got_header.frame_bytes, frame_bytes);
        check_field("has_frame_bytes", got_header.has_frame_bytes, has_frame_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
